// File: rtl/lru_pr_pkg.sv
// Types and constants for the LRU page replacement block.
// No dependencies; imported by lru_page_replacement.
package lru_pr_pkg;

   // Sizing
   localparam int MAX_FRAMES  = 16;
   localparam int PAGE_BITS   = 16;
   localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
   localparam int RANK_W      = $clog2(MAX_FRAMES);
   localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);
   localparam int FAULT_W     = 16;

   typedef logic [PAGE_BITS-1:0]   page_type;
   typedef logic [FRAME_IDX_W-1:0] frame_idx_type;
   typedef logic [RANK_W-1:0]      rank_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [FAULT_W-1:0]     fault_type;

   // Request commands
   localparam logic CMD_REFERENCE = 1'b0;
   localparam logic CMD_CLEAR     = 1'b1;

   localparam count_type FRAMES_RESET = count_type'(MAX_FRAMES);
   localparam count_type FRAMES_MAX   = count_type'(MAX_FRAMES);
   localparam rank_type  RANK_MAX     = rank_type'(MAX_FRAMES - 1);
   localparam fault_type FAULT_MAX    = '1;

endpackage

// File: rtl/lru_page_replacement.sv
// Fully associative LRU page replacement: frame store, serial frame scan and update.
// Depends on lru_pr_pkg.
//
// A request is taken while idle, then the frames are examined one per cycle by a
// single compare unit (page match, first empty frame, oldest rank), stopping at the
// first matching frame, else after the last active frame; the update state then
// commits the update and loads the response register once the output is free.
// A clear request goes to the clear state, which empties frames and fault count.
// The response register lets the next request be taken while a response still
// waits. A configured frame count of 0 acts as 1, above 16 as 16.
module lru_page_replacement (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  lru_pr_pkg::page_type      req_page_number,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output lru_pr_pkg::frame_idx_type rsp_frame_index,
   output logic                      rsp_evicted_valid,
   output lru_pr_pkg::page_type      rsp_evicted_page,
   output lru_pr_pkg::fault_type     rsp_fault_count,
   // configuration
   input  logic                      csr_wr_en,
   input  logic [4:0]                csr_wr_data
);
   import lru_pr_pkg::*;

   // Sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_CLEAR  = 2'd3;

   logic [1:0]    state_ff, state_in;
   count_type     frames_cfg_ff;

   // Frame store
   page_type      page_mem_ff [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   rank_type      rank_ff [MAX_FRAMES];
   rank_type      rank_in [MAX_FRAMES];
   fault_type     faults_ff, faults_in;

   // Request and scan tracking
   page_type      page_ff;
   frame_idx_type scan_k_ff;
   logic          found_ff;
   frame_idx_type match_idx_ff;
   rank_type      match_rank_ff;
   logic          empty_found_ff;
   frame_idx_type empty_idx_ff;
   rank_type      best_rank_ff;
   frame_idx_type best_idx_ff;
   page_type      best_page_ff;

   // Response register
   logic          rsp_valid_ff;
   logic          rsp_hit_ff;
   frame_idx_type rsp_frame_ff;
   logic          rsp_ev_valid_ff;
   page_type      rsp_ev_page_ff;
   fault_type     rsp_faults_ff;

   logic          req_accept;
   logic          out_free;
   count_type     active_n;
   count_type     last_tmp;
   frame_idx_type last_k;
   page_type      scan_page;
   rank_type      scan_rank;
   logic          scan_match;
   frame_idx_type tgt_idx;
   count_type     old_rank;
   logic          page_wr_en;
   logic          commit;

   // Active frame count, clamped to 1..MAX_FRAMES
   always_comb begin
      if (frames_cfg_ff == '0) begin
         active_n = count_type'(1);
      end else if (frames_cfg_ff > FRAMES_MAX) begin
         active_n = FRAMES_MAX;
      end else begin
         active_n = frames_cfg_ff;
      end
      last_tmp = active_n - count_type'(1);
      last_k   = last_tmp[FRAME_IDX_W-1:0];
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = (state_ff == ST_UPDATE) && out_free;

   // Shared compare unit: one frame per scan cycle
   assign scan_page  = page_mem_ff[scan_k_ff];
   assign scan_rank  = rank_ff[scan_k_ff];
   assign scan_match = valid_ff[scan_k_ff] && (scan_page == page_ff);

   // Frame chosen for this reference and the rank it held before
   always_comb begin
      if (found_ff) begin
         tgt_idx  = match_idx_ff;
         old_rank = {1'b0, match_rank_ff};
      end else if (empty_found_ff) begin
         tgt_idx  = empty_idx_ff;
         old_rank = count_type'(MAX_FRAMES);
      end else begin
         tgt_idx  = best_idx_ff;
         old_rank = {1'b0, best_rank_ff};
      end
   end

   assign page_wr_en = commit && !found_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_command == CMD_CLEAR) ? ST_CLEAR : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_match || (scan_k_ff == last_k)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Valid bits, recency ranks and fault count
   always_comb begin
      valid_in  = valid_ff;
      faults_in = faults_ff;
      for (int k = 0; k < MAX_FRAMES; k++) begin
         rank_in[k] = rank_ff[k];
      end
      if ((state_ff == ST_CLEAR) && out_free) begin
         valid_in  = '0;
         faults_in = '0;
      end else if (commit) begin
         // age every active valid frame that was more recent than the target
         for (int k = 0; k < MAX_FRAMES; k++) begin
            if ((count_type'(k) < active_n) && (frame_idx_type'(k) != tgt_idx) &&
                valid_ff[k] && ({1'b0, rank_ff[k]} < old_rank) &&
                (rank_ff[k] != RANK_MAX)) begin
               rank_in[k] = rank_ff[k] + rank_type'(1);
            end
         end
         rank_in[tgt_idx]  = '0;
         valid_in[tgt_idx] = 1'b1;
         if (!found_ff && (faults_ff != FAULT_MAX)) begin
            faults_in = faults_ff + fault_type'(1);
         end
      end
   end

   // Page store
   always_ff @(posedge clock) begin
      if (page_wr_en) begin
         page_mem_ff[tgt_idx] <= page_ff;
      end
   end

   // Ranks carry no reset: a frame's rank is set whenever it fills
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
         rank_ff[k] <= rank_in[k];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frames_cfg_ff <= FRAMES_RESET;
         valid_ff      <= '0;
         faults_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         faults_ff <= faults_in;
         if (csr_wr_en) begin
            frames_cfg_ff <= csr_wr_data;
         end
         if (commit || ((state_ff == ST_CLEAR) && out_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture and scan tracking
   always_ff @(posedge clock) begin
      if (req_accept) begin
         page_ff        <= req_page_number;
         scan_k_ff      <= '0;
         found_ff       <= 1'b0;
         empty_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (scan_match) begin
            found_ff      <= 1'b1;
            match_idx_ff  <= scan_k_ff;
            match_rank_ff <= scan_rank;
         end else begin
            if (!valid_ff[scan_k_ff] && !empty_found_ff) begin
               empty_found_ff <= 1'b1;
               empty_idx_ff   <= scan_k_ff;
            end
            // oldest frame, lowest index on a tie
            if ((scan_k_ff == '0) || (scan_rank > best_rank_ff)) begin
               best_rank_ff <= scan_rank;
               best_idx_ff  <= scan_k_ff;
               best_page_ff <= scan_page;
            end
            if (scan_k_ff != last_k) begin
               scan_k_ff <= scan_k_ff + frame_idx_type'(1);
            end
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if ((state_ff == ST_CLEAR) && out_free) begin
         rsp_hit_ff      <= 1'b0;
         rsp_frame_ff    <= '0;
         rsp_ev_valid_ff <= 1'b0;
         rsp_ev_page_ff  <= '0;
         rsp_faults_ff   <= '0;
      end else if (commit) begin
         rsp_hit_ff      <= found_ff;
         rsp_frame_ff    <= tgt_idx;
         rsp_ev_valid_ff <= !found_ff && !empty_found_ff;
         rsp_ev_page_ff  <= (!found_ff && !empty_found_ff) ? best_page_ff : '0;
         rsp_faults_ff   <= faults_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_faults_ff;

   // Checks
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ({1'b0, scan_k_ff} < active_n))
      else $error("scan index beyond active frames");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_ev_valid_ff))
      else $error("hit reported together with eviction");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ev_valid_ff) |-> (rsp_ev_page_ff == '0))
      else $error("evicted page not zero without eviction");

   a_hit_keeps_faults: assert property (@(posedge clock) disable iff (reset)
      (commit && found_ff) |=> (faults_ff == $past(faults_ff)))
      else $error("fault count changed on a hit");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR) && out_free) |=> ((valid_ff == '0) && (faults_ff == '0)))
      else $error("clear left frames or faults behind");

endmodule
